// ===== rtl/mvt_pkg.sv =====
// ----------------------------------------------------------------------------
// mvt_pkg
// Shared types and constants of the morphing vertex transform.
// ----------------------------------------------------------------------------
package mvt_pkg;

  localparam int CoordW = 32;
  localparam int CoefW  = 18;
  localparam int LerpW  = 16;
  localparam int FracW  = 16;
  localparam int RowW   = 3 * CoefW;
  localparam int CfgIdxW = 3;
  // Full product of a 2.16 coefficient and a coordinate.
  localparam int ProdW  = CoefW + CoordW;

  localparam logic [LerpW-1:0]        LerpFull = 16'hffff;
  // 4/3 in 2.16.
  localparam logic signed [CoefW-1:0] YScale   = 18'sd87381;

  localparam int ModeMorphBit  = 0;
  localparam int ModePreOffBit = 1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ROW_X  = 3'd0,
    CFG_ROW_Y  = 3'd1,
    CFG_ROW_Z  = 3'd2,
    CFG_OFF_X  = 3'd3,
    CFG_OFF_Y  = 3'd4,
    CFG_OFF_Z  = 3'd5,
    CFG_LERP   = 3'd6,
    CFG_MODE   = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    BLEND_FIRST  = 2'd0,
    BLEND_SECOND = 2'd1,
    BLEND_MIX    = 2'd2
  } blend_sel_e;

  // One matrix row: c0 weights x, c1 weights y, c2 weights z.
  typedef struct packed {
    logic signed [CoefW-1:0] c2;
    logic signed [CoefW-1:0] c1;
    logic signed [CoefW-1:0] c0;
  } row_t;

  // Control that travels with a row into the dot-product unit.
  typedef struct packed {
    logic add_offset;
  } row_ctrl_t;

endpackage

// ===== rtl/mvt_row.sv =====
// ----------------------------------------------------------------------------
// mvt_row
// Two-stage 16.16 dot product of one matrix row with a point, plus an optional offset.
// ----------------------------------------------------------------------------
module mvt_row (
  input  logic                                 clk_i,
  input  mvt_pkg::row_t                        row_i,
  input  logic signed [mvt_pkg::CoordW-1:0]    point_i [3],
  input  logic signed [mvt_pkg::CoordW-1:0]    offset_i,
  input  mvt_pkg::row_ctrl_t                   ctrl_i,
  output logic signed [mvt_pkg::CoordW-1:0]    sum_o
);

  logic signed [mvt_pkg::CoefW-1:0]  coef [3];
  logic signed [mvt_pkg::ProdW-1:0]  prod [3];
  logic signed [mvt_pkg::CoordW-1:0] prod_q [3];
  logic signed [mvt_pkg::CoordW-1:0] offset_q;
  logic signed [mvt_pkg::CoordW-1:0] sum_d;
  logic signed [mvt_pkg::CoordW-1:0] sum_q;

  assign coef[0] = row_i.c0;
  assign coef[1] = row_i.c1;
  assign coef[2] = row_i.c2;

  // Floor shift by 16 then wrap to 32 bits: keep bits 47..16.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod[k] = coef[k] * point_i[k];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      prod_q[k] <= prod[k][mvt_pkg::FracW +: mvt_pkg::CoordW];
    end
    offset_q <= ctrl_i.add_offset ? offset_i : '0;
  end

  assign sum_d = prod_q[0] + prod_q[1] + prod_q[2] + offset_q;

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
  end

  assign sum_o = sum_q;

endmodule

// ===== rtl/morph_vertex_transform.sv =====
// ----------------------------------------------------------------------------
// morph_vertex_transform
// Blend a vertex with its morph target, rotate it in 16.16, offset, scale y.
// ----------------------------------------------------------------------------
// A request taken at an edge moves through stages s1 to s5 and then shows on done_o.
// Throughput: one vertex per clock; busy is held low, the pipeline never stops.
// Pipeline: blend multiply, blend add and pre-offset, row products,
//   row sums and post-offset, y scale into the output registers.
// Reset: clears all configuration registers and the valid pipeline.
// ----------------------------------------------------------------------------
module morph_vertex_transform (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration writes
  input  logic                                 cfg_we_i,
  input  logic [mvt_pkg::CfgIdxW-1:0]          cfg_idx_i,
  input  logic [mvt_pkg::RowW-1:0]             cfg_wdata_i,
  // request side
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [mvt_pkg::CoordW-1:0]    first_x_i,
  input  logic signed [mvt_pkg::CoordW-1:0]    first_y_i,
  input  logic signed [mvt_pkg::CoordW-1:0]    first_z_i,
  input  logic signed [mvt_pkg::CoordW-1:0]    second_x_i,
  input  logic signed [mvt_pkg::CoordW-1:0]    second_y_i,
  input  logic signed [mvt_pkg::CoordW-1:0]    second_z_i,
  input  logic                                 last_vertex_i,
  // result side
  output logic                                 done_o,
  output logic signed [mvt_pkg::CoordW-1:0]    view_x_o,
  output logic signed [mvt_pkg::CoordW-1:0]    view_y_o,
  output logic signed [mvt_pkg::CoordW-1:0]    view_z_o,
  output logic signed [mvt_pkg::CoordW-1:0]    blended_x_o,
  output logic signed [mvt_pkg::CoordW-1:0]    blended_y_o,
  output logic signed [mvt_pkg::CoordW-1:0]    blended_z_o,
  output logic                                 last_out_o
);

  localparam int CW = mvt_pkg::CoordW;
  // (b - a) needs one bit more than a coordinate; lerp is zero-extended.
  localparam int DiffW  = CW + 1;
  localparam int BProdW = DiffW + mvt_pkg::LerpW + 1;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  mvt_pkg::row_t                 row_q [3];
  logic signed [CW-1:0]          off_q [3];
  logic [mvt_pkg::LerpW-1:0]     lerp_q;
  logic [1:0]                    mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        row_q[k] <= '0;
        off_q[k] <= '0;
      end
      lerp_q <= '0;
      mode_q <= '0;
    end else if (cfg_we_i) begin
      unique case (mvt_pkg::cfg_idx_e'(cfg_idx_i))
        mvt_pkg::CFG_ROW_X: row_q[0] <= mvt_pkg::row_t'(cfg_wdata_i);
        mvt_pkg::CFG_ROW_Y: row_q[1] <= mvt_pkg::row_t'(cfg_wdata_i);
        mvt_pkg::CFG_ROW_Z: row_q[2] <= mvt_pkg::row_t'(cfg_wdata_i);
        mvt_pkg::CFG_OFF_X: off_q[0] <= cfg_wdata_i[CW-1:0];
        mvt_pkg::CFG_OFF_Y: off_q[1] <= cfg_wdata_i[CW-1:0];
        mvt_pkg::CFG_OFF_Z: off_q[2] <= cfg_wdata_i[CW-1:0];
        mvt_pkg::CFG_LERP:  lerp_q   <= cfg_wdata_i[mvt_pkg::LerpW-1:0];
        mvt_pkg::CFG_MODE:  mode_q   <= cfg_wdata_i[1:0];
      endcase
    end
  end

  // The pipeline always advances, so a request is never held off.
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // --------------------------------------------------------------------------
  // Stage 1: pick the blend source and form (b - a) * lerp
  // --------------------------------------------------------------------------
  logic signed [CW-1:0]     in_a [3];
  logic signed [CW-1:0]     in_b [3];
  logic signed [DiffW-1:0]  diff [3];
  logic signed [BProdW-1:0] bprod [3];
  logic signed [mvt_pkg::LerpW:0] lerp_s;
  logic                     same_vertex;
  mvt_pkg::blend_sel_e      sel_d;

  assign in_a[0] = first_x_i;
  assign in_a[1] = first_y_i;
  assign in_a[2] = first_z_i;
  assign in_b[0] = second_x_i;
  assign in_b[1] = second_y_i;
  assign in_b[2] = second_z_i;

  assign lerp_s      = $signed({1'b0, lerp_q});
  assign same_vertex = (first_x_i == second_x_i) && (first_y_i == second_y_i)
                    && (first_z_i == second_z_i);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k]  = DiffW'(in_b[k]) - DiffW'(in_a[k]);
      bprod[k] = diff[k] * lerp_s;
    end
  end

  // Morph off, identical vertices or a zero factor all keep the base vertex.
  always_comb begin
    priority if (!mode_q[mvt_pkg::ModeMorphBit] || same_vertex || lerp_q == '0) begin
      sel_d = mvt_pkg::BLEND_FIRST;
    end else if (lerp_q == mvt_pkg::LerpFull) begin
      sel_d = mvt_pkg::BLEND_SECOND;
    end else begin
      sel_d = mvt_pkg::BLEND_MIX;
    end
  end

  logic                 s1_valid_q;
  logic                 s1_last_q;
  mvt_pkg::blend_sel_e  s1_sel_q;
  logic signed [CW-1:0] s1_a_q [3];
  logic signed [CW-1:0] s1_b_q [3];
  logic signed [CW-1:0] s1_step_q [3];

  // Floor shift by 16 and wrap: bits 47..16 of the product are all we add.
  always_ff @(posedge clk_i) begin
    s1_last_q <= last_vertex_i;
    s1_sel_q  <= sel_d;
    for (int k = 0; k < 3; k++) begin
      s1_a_q[k]    <= in_a[k];
      s1_b_q[k]    <= in_b[k];
      s1_step_q[k] <= bprod[k][mvt_pkg::FracW +: CW];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: finish the blend, add the offset ahead of rotation if asked
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] blend_d [3];
  logic signed [CW-1:0] point_d [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      unique case (s1_sel_q)
        mvt_pkg::BLEND_SECOND: blend_d[k] = s1_b_q[k];
        mvt_pkg::BLEND_MIX:    blend_d[k] = s1_a_q[k] + s1_step_q[k];
        default:               blend_d[k] = s1_a_q[k];
      endcase
      point_d[k] = mode_q[mvt_pkg::ModePreOffBit] ? blend_d[k] + off_q[k] : blend_d[k];
    end
  end

  logic                 s2_valid_q;
  logic                 s2_last_q;
  logic signed [CW-1:0] s2_blend_q [3];
  logic signed [CW-1:0] s2_point_q [3];

  always_ff @(posedge clk_i) begin
    s2_last_q <= s1_last_q;
    for (int k = 0; k < 3; k++) begin
      s2_blend_q[k] <= blend_d[k];
      s2_point_q[k] <= point_d[k];
    end
  end

  // --------------------------------------------------------------------------
  // Stages 3 and 4: one dot-product unit per view axis
  // --------------------------------------------------------------------------
  mvt_pkg::row_ctrl_t   row_ctrl;
  logic signed [CW-1:0] view_sum [3];

  assign row_ctrl.add_offset = !mode_q[mvt_pkg::ModePreOffBit];

  for (genvar r = 0; r < 3; r++) begin : g_row
    mvt_row u_row (
      .clk_i    (clk_i),
      .row_i    (row_q[r]),
      .point_i  (s2_point_q),
      .offset_i (off_q[r]),
      .ctrl_i   (row_ctrl),
      .sum_o    (view_sum[r])
    );
  end

  // Carry the blended point and the end marker alongside the row units.
  logic                 s3_valid_q;
  logic                 s3_last_q;
  logic signed [CW-1:0] s3_blend_q [3];
  logic                 s4_valid_q;
  logic                 s4_last_q;
  logic signed [CW-1:0] s4_blend_q [3];

  always_ff @(posedge clk_i) begin
    s3_last_q  <= s2_last_q;
    s3_blend_q <= s2_blend_q;
    s4_last_q  <= s3_last_q;
    s4_blend_q <= s3_blend_q;
  end

  // --------------------------------------------------------------------------
  // Stage 5: scale y by 4/3 into the output registers
  // --------------------------------------------------------------------------
  logic signed [mvt_pkg::ProdW-1:0] yprod;

  assign yprod = view_sum[1] * mvt_pkg::YScale;

  logic                 s5_valid_q;
  logic                 s5_last_q;
  logic signed [CW-1:0] s5_view_q [3];
  logic signed [CW-1:0] s5_blend_q [3];

  always_ff @(posedge clk_i) begin
    s5_last_q    <= s4_last_q;
    s5_view_q[0] <= view_sum[0];
    s5_view_q[1] <= yprod[mvt_pkg::FracW +: CW];
    s5_view_q[2] <= view_sum[2];
    s5_blend_q   <= s4_blend_q;
  end

  // --------------------------------------------------------------------------
  // Valid pipeline
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
      s5_valid_q <= s4_valid_q;
    end
  end

  assign done_o      = s5_valid_q;
  assign view_x_o    = s5_view_q[0];
  assign view_y_o    = s5_view_q[1];
  assign view_z_o    = s5_view_q[2];
  assign blended_x_o = s5_blend_q[0];
  assign blended_y_o = s5_blend_q[1];
  assign blended_z_o = s5_blend_q[2];
  assign last_out_o  = s5_last_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_req_to_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##5 done_o)
    else $error("request did not reach the output after five cycles");

  a_done_from_req : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 5))
    else $error("result strobe without a matching request");

  a_keep_first : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_sel_q == mvt_pkg::BLEND_FIRST)
      |=> (s2_blend_q[0] == $past(s1_a_q[0]) && s2_blend_q[2] == $past(s1_a_q[2])))
    else $error("base vertex not kept when blending is off");

  a_take_second : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_sel_q == mvt_pkg::BLEND_SECOND)
      |=> (s2_blend_q[1] == $past(s1_b_q[1])))
    else $error("target vertex not taken at full blend factor");

endmodule
